### sv/salsa_pkg.sv
// ============================================================================
// salsa_pkg
// shared types, constants and round functions of the salsa20 stream block
// ============================================================================
`default_nettype none

package salsa_pkg;

   typedef logic [31:0] word_type;
   typedef word_type    wstate_type [16];

   // buffer layout: two banks of sixteen 32-bit words
   localparam int WordAw  = 4;
   localparam int BufAw   = WordAw + 1;
   localparam int PosW    = 6;
   localparam int StepW   = 6;
   localparam int LastStep = 39;   // ten double rounds, four half steps each

   // register indexes
   localparam logic [2:0] REG_KEY_LO  = 3'd0;
   localparam logic [2:0] REG_KEY_ML  = 3'd1;
   localparam logic [2:0] REG_KEY_MH  = 3'd2;
   localparam logic [2:0] REG_KEY_HI  = 3'd3;
   localparam logic [2:0] REG_NONCE   = 3'd4;

   localparam word_type SIGMA0 = 32'h6170_7865;
   localparam word_type SIGMA1 = 32'h3320_646e;
   localparam word_type SIGMA2 = 32'h7962_2d32;
   localparam word_type SIGMA3 = 32'h6b20_6574;

   // quarter-round word indexes: column round, then row round
   localparam logic [3:0] COL_IDX [4][4] = '{
      '{4'd0,  4'd4,  4'd8,  4'd12},
      '{4'd5,  4'd9,  4'd13, 4'd1},
      '{4'd10, 4'd14, 4'd2,  4'd6},
      '{4'd15, 4'd3,  4'd7,  4'd11}};
   localparam logic [3:0] ROW_IDX [4][4] = '{
      '{4'd0,  4'd1,  4'd2,  4'd3},
      '{4'd5,  4'd6,  4'd7,  4'd4},
      '{4'd10, 4'd11, 4'd8,  4'd9},
      '{4'd15, 4'd12, 4'd13, 4'd14}};

   // generator write port toward the buffer
   typedef struct packed {
      logic             en;
      logic [BufAw-1:0] addr;
      word_type         data;
   } kwr_type;

   // block request toward the generator
   typedef struct packed {
      logic     start;
      logic     kill;
      logic     bank;
      word_type count;
   } gen_ctl_type;

   function automatic word_type rotl(input word_type v, input int s);
      rotl = (v << s) | (v >> (32 - s));
   endfunction

   // initial state word of a block
   function automatic word_type init_word(input logic [3:0] idx,
                                          input logic [63:0] k0,
                                          input logic [63:0] k1,
                                          input logic [63:0] k2,
                                          input logic [63:0] k3,
                                          input logic [63:0] nonce,
                                          input word_type cnt);
      case (idx)
         4'd0:    init_word = SIGMA0;
         4'd1:    init_word = k0[31:0];
         4'd2:    init_word = k0[63:32];
         4'd3:    init_word = k1[31:0];
         4'd4:    init_word = k1[63:32];
         4'd5:    init_word = SIGMA1;
         4'd6:    init_word = nonce[31:0];
         4'd7:    init_word = nonce[63:32];
         4'd8:    init_word = cnt;
         4'd9:    init_word = '0;
         4'd10:   init_word = SIGMA2;
         4'd11:   init_word = k2[31:0];
         4'd12:   init_word = k2[63:32];
         4'd13:   init_word = k3[31:0];
         4'd14:   init_word = k3[63:32];
         default: init_word = SIGMA3;
      endcase
   endfunction

   // half of a column or row round: first or second pair of quarter steps
   function automatic wstate_type half_round(input wstate_type w,
                                             input logic row,
                                             input logic second);
      wstate_type r;
      logic [3:0] a, b, c, d;
      word_type   t0, t1;
      r = w;
      for (int q = 0; q < 4; q++) begin
         a = row ? ROW_IDX[q][0] : COL_IDX[q][0];
         b = row ? ROW_IDX[q][1] : COL_IDX[q][1];
         c = row ? ROW_IDX[q][2] : COL_IDX[q][2];
         d = row ? ROW_IDX[q][3] : COL_IDX[q][3];
         if (!second) begin
            t0   = w[b] ^ rotl(w[a] + w[d], 7);
            t1   = w[c] ^ rotl(t0 + w[a], 9);
            r[b] = t0;
            r[c] = t1;
         end else begin
            t0   = w[d] ^ rotl(w[c] + w[b], 13);
            t1   = w[a] ^ rotl(t0 + w[c], 18);
            r[d] = t0;
            r[a] = t1;
         end
      end
      half_round = r;
   endfunction

endpackage

`default_nettype wire

### sv/salsa_kbuf.sv
// ============================================================================
// salsa_kbuf
// keystream buffer: two banks of sixteen words, one write and one read port
// ============================================================================
`default_nettype none

module salsa_kbuf (
   input  wire logic                     clock,
   input  wire salsa_pkg::kwr_type       wr,
   input  wire logic                     rd_en,
   input  wire logic [salsa_pkg::BufAw-1:0] rd_addr,
   output      salsa_pkg::word_type      rd_data
);
   import salsa_pkg::*;

   word_type mem [2**BufAw];
   word_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // registered read, held while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/salsa_core.sv
// ============================================================================
// salsa_core
// block generator: ten double rounds, feed-forward add, word writes to buffer
// ============================================================================
`default_nettype none

module salsa_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire salsa_pkg::gen_ctl_type ctl,
   input  wire logic [63:0]            key0,
   input  wire logic [63:0]            key1,
   input  wire logic [63:0]            key2,
   input  wire logic [63:0]            key3,
   input  wire logic [63:0]            nonce,
   output      salsa_pkg::kwr_type     wr,
   output      logic                   done
);
   import salsa_pkg::*;

   typedef enum logic [1:0] {IDLE, ROUNDS, STORE} gstate_type;

   gstate_type        state_ff;
   logic [StepW-1:0]  step_ff;
   logic [WordAw-1:0] idx_ff;
   logic              bank_ff;
   word_type          cnt_ff;
   wstate_type        w_ff;
   wstate_type        w_in;
   wstate_type        w_init;

   // initial block state from the live registers
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         w_init[i] = init_word(4'(i), key0, key1, key2, key3, nonce, ctl.count);
      end
   end

   assign w_in = half_round(w_ff, step_ff[1], step_ff[0]);

   // sequencer and working state
   always_ff @(posedge clock) begin
      if (reset || ctl.kill) begin
         state_ff <= IDLE;
         step_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (ctl.start) begin
                  state_ff <= ROUNDS;
                  step_ff  <= '0;
                  bank_ff  <= ctl.bank;
                  cnt_ff   <= ctl.count;
                  w_ff     <= w_init;
               end
            end
            ROUNDS: begin
               w_ff <= w_in;
               if (step_ff == StepW'(LastStep)) begin
                  state_ff <= STORE;
                  idx_ff   <= '0;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            STORE: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == '1) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   // feed-forward add, one word per cycle into the buffer
   always_comb begin
      wr.en   = (state_ff == STORE) && !ctl.kill;
      wr.addr = {bank_ff, idx_ff};
      wr.data = w_ff[idx_ff] + init_word(idx_ff, key0, key1, key2, key3, nonce, cnt_ff);
   end

   assign done = wr.en && (idx_ff == '1);

endmodule

`default_nettype wire

### sv/salsa20_stream_xor_top.sv
// ============================================================================
// salsa20_stream_xor_top
// salsa20/20 stream cipher, one byte in and one byte out per request
// ============================================================================
// Each request byte is XORed with the next keystream byte. Keystream blocks
// are built by a generator (one load, 40 half-round steps, 16 word writes per
// 64-byte block) into the idle bank of a two-bank buffer, so within a
// message the next block is ready before it is needed and, unless the output
// stalls, the block streams one byte per cycle. After a request with last_byte
// set, and after any register write, the prefetched block is discarded: the
// first byte of the next block waits for the generator to rebuild it.
// Results pass a buffer read stage and an output register. Key and nonce
// are sampled when a block is built.
`default_nettype none

module salsa20_stream_xor_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [7:0]  rsp_out_byte,
   output      logic        rsp_out_last,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import salsa_pkg::*;

   logic [63:0]      key0_ff, key1_ff, key2_ff, key3_ff, nonce_ff;
   logic [PosW-1:0]  pos_ff;
   word_type         cnt_ff;
   logic             cur_bank_ff;
   logic             nxt_ok_ff;
   logic             s1_v_ff;
   logic [7:0]       s1_data_ff;
   logic             s1_last_ff;
   logic [1:0]       s1_sel_ff;
   logic             out_v_ff;
   logic [7:0]       out_byte_ff;
   logic             out_last_ff;

   logic             csr_wr;
   logic             req_acc;
   logic             pos_zero;
   logic             out_free;
   logic             s1_move;
   logic             rd_bank;
   gen_ctl_type      gen_ctl;
   kwr_type          kwr;
   logic             gen_done;
   word_type         rd_word;
   logic             gen_busy_ff;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff  <= '0;
         key1_ff  <= '0;
         key2_ff  <= '0;
         key3_ff  <= '0;
         nonce_ff <= '0;
      end else if (csr_wr) begin
         case (csr_index)
            REG_KEY_LO: key0_ff  <= csr_data;
            REG_KEY_ML: key1_ff  <= csr_data;
            REG_KEY_MH: key2_ff  <= csr_data;
            REG_KEY_HI: key3_ff  <= csr_data;
            REG_NONCE:  nonce_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // request flow
   assign pos_zero  = (pos_ff == '0);
   assign out_free  = !out_v_ff || !rsp_stall;
   assign s1_move   = s1_v_ff && out_free;
   assign req_stall = !((!s1_v_ff || out_free) && (!pos_zero || nxt_ok_ff));
   assign req_acc   = req_valid && !req_stall;
   assign rd_bank   = pos_zero ? !cur_bank_ff : cur_bank_ff;

   // generator control: next block goes to the bank not being read
   always_comb begin
      gen_ctl.kill  = csr_wr || (req_acc && req_last_byte);
      gen_ctl.start = !gen_busy_ff && !nxt_ok_ff && !gen_ctl.kill;
      gen_ctl.bank  = !cur_bank_ff;
      gen_ctl.count = cnt_ff;
   end

   // position, block counter and bank bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         cnt_ff      <= '0;
         cur_bank_ff <= 1'b0;
         nxt_ok_ff   <= 1'b0;
         gen_busy_ff <= 1'b0;
      end else begin
         if (gen_ctl.start) begin
            gen_busy_ff <= 1'b1;
         end
         if (gen_done) begin
            gen_busy_ff <= 1'b0;
            nxt_ok_ff   <= 1'b1;
         end
         if (req_acc && pos_zero) begin
            cur_bank_ff <= !cur_bank_ff;
            nxt_ok_ff   <= 1'b0;
            cnt_ff      <= cnt_ff + 1'b1;
         end
         if (req_acc) begin
            pos_ff <= pos_ff + 1'b1;
         end
         if (gen_ctl.kill) begin
            nxt_ok_ff   <= 1'b0;
            gen_busy_ff <= 1'b0;
         end
         if (req_acc && req_last_byte) begin
            pos_ff <= '0;
            cnt_ff <= '0;
         end
      end
   end

   salsa_core u_core (
      .clock (clock),
      .reset (reset),
      .ctl   (gen_ctl),
      .key0  (key0_ff),
      .key1  (key1_ff),
      .key2  (key2_ff),
      .key3  (key3_ff),
      .nonce (nonce_ff),
      .wr    (kwr),
      .done  (gen_done)
   );

   salsa_kbuf u_kbuf (
      .clock   (clock),
      .wr      (kwr),
      .rd_en   (req_acc),
      .rd_addr ({rd_bank, pos_ff[PosW-1:2]}),
      .rd_data (rd_word)
   );

   // read stage and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (req_acc) begin
            s1_v_ff <= 1'b1;
         end else if (s1_move) begin
            s1_v_ff <= 1'b0;
         end
         if (s1_move) begin
            out_v_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_data_ff <= req_data_byte;
         s1_last_ff <= req_last_byte;
         s1_sel_ff  <= pos_ff[1:0];
      end
      if (s1_move) begin
         out_byte_ff <= s1_data_ff ^ rd_word[{s1_sel_ff, 3'b000} +: 8];
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid    = out_v_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_out_last = out_last_ff;

`ifndef SYNTHESIS
   // a block start is only taken from a finished prefetch
   a_block_ready: assert property (@(posedge clock) disable iff (reset)
      (req_acc && pos_zero) |-> nxt_ok_ff)
      else $error("block start without prefetched keystream");

   // the generator never writes the bank being read
   a_bank_sep: assert property (@(posedge clock) disable iff (reset)
      kwr.en |-> (kwr.addr[BufAw-1] != cur_bank_ff))
      else $error("generator write into active bank");

   // a last byte restarts position and counter
   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_last_byte) |=> (pos_ff == '0 && cnt_ff == '0 && !nxt_ok_ff))
      else $error("message end did not restart stream");
`endif

endmodule

`default_nettype wire
